@@ hdl/sit_pkg.sv @@
// ============================================================================
// sit_pkg: shared types for the sorted insert table
// Command codes, fixed result field widths and the per-cell control word.
// ============================================================================
package sit_pkg;

    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int INDEX_W = 4;
    localparam int TOTAL_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DUMP   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  new_value;
    } cell_ctl_t;

endpackage

@@ hdl/sit_if.sv @@
// ============================================================================
// sit_if: valid/ready channels of the sorted insert table
// Command channel and result channel, each with source and sink modports.
// ============================================================================
interface sit_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [sit_pkg::CMD_W-1:0]            command;
    logic signed [sit_pkg::VALUE_W-1:0]   new_value;

    modport source (output valid, output command, output new_value, input ready);
    modport sink   (input valid, input command, input new_value, output ready);
endinterface

interface sit_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sit_pkg::VALUE_W-1:0]   result_value;
    logic [sit_pkg::INDEX_W-1:0]          result_index;
    logic [sit_pkg::TOTAL_W-1:0]          entry_total;
    logic                                 dropped;
    logic                                 last_of_run;

    modport source (output valid, output result_value, output result_index,
                    output entry_total, output dropped, output last_of_run,
                    input ready);
    modport sink   (input valid, input result_value, input result_index,
                    input entry_total, input dropped, input last_of_run,
                    output ready);
endinterface

@@ hdl/sorted_insert_table.sv @@
// ============================================================================
// sorted_insert_table: ascending table of signed 32-bit values
// Row of compare-and-shift cells with a small command sequencer.
// ============================================================================
// An insert or clear is accepted and its single result word is registered;
// a new command is taken as soon as the result register is empty or being
// drained. A dump gives count words, or one word for an empty table; for a
// filled table it first enters the dump state, then streams one word per
// cycle while the result register can load, by rotating the occupied cells
// past slot 0; the command channel is held off until the last word is
// loaded. Inserts into a full table are refused with dropped set. Equal
// values keep arrival order. Command code 3 is accepted and ignored.
module sorted_insert_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    sit_cmd_if.sink            in_ch,
    sit_rsp_if.source          out_ch
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int VW = sit_pkg::VALUE_W;
    localparam int IW = sit_pkg::INDEX_W;
    localparam int TW = sit_pkg::TOTAL_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic {S_IDLE, S_DUMP} state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          dump_idx_reg, dump_idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [VW-1:0]   out_value_reg, out_value_next;
    logic [IW-1:0]          out_index_reg, out_index_next;
    logic [TW-1:0]          out_total_reg, out_total_next;
    logic                   out_drop_reg, out_drop_next;
    logic                   out_last_reg, out_last_next;

    logic                   can_load;
    logic                   accept;
    logic                   full;
    logic [CW-1:0]          ins_pos;
    logic signed [VW-1:0]   ins_min;
    sit_pkg::cell_ctl_t     ctl;

    logic signed [VW-1:0]   cell_val   [TABLE_DEPTH];
    logic signed [VW-1:0]   cell_left  [TABLE_DEPTH];
    logic signed [VW-1:0]   cell_right [TABLE_DEPTH];
    logic                   cell_lgt   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_gt;
    logic [TABLE_DEPTH-1:0] cell_take;

    assign can_load    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && can_load;
    assign accept      = in_ch.valid && in_ch.ready;
    assign full        = count_reg >= DEPTH_C;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign cell_left[g] = cell_val[g];
                assign cell_lgt[g]  = 1'b0;
            end
            else
            begin : g_body
                assign cell_left[g] = cell_val[g-1];
                assign cell_lgt[g]  = cell_gt[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_tail
                assign cell_right[g] = cell_val[g];
            end
            else
            begin : g_mid
                assign cell_right[g] = cell_val[g+1];
            end

            sit_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .count       (count_reg),
                .left_value  (cell_left[g]),
                .left_gt     (cell_lgt[g]),
                .right_value (cell_right[g]),
                .first_value (cell_val[0]),
                .value       (cell_val[g]),
                .gt          (cell_gt[g]),
                .take_new    (cell_take[g])
            );
        end
    endgenerate

    // exactly one cell takes the new value; encode its position
    always_comb
    begin
        ins_pos = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (cell_take[i])
            begin
                ins_pos = ins_pos | CW'(i);
            end
        end
    end

    assign ins_min = ((count_reg == '0) || cell_gt[0]) ? in_ch.new_value : cell_val[0];

    always_comb
    begin
        ctl.new_value  = in_ch.new_value;
        ctl.op         = sit_pkg::CELL_HOLD;
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_total_next = out_total_reg;
        out_drop_next  = out_drop_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.command)
                        sit_pkg::CMD_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (full)
                            begin
                                out_value_next = cell_val[0];
                                out_index_next = '0;
                                out_total_next = TW'(count_reg);
                                out_drop_next  = 1'b1;
                            end
                            else
                            begin
                                ctl.op         = sit_pkg::CELL_INSERT;
                                count_next     = count_reg + 1'b1;
                                out_value_next = ins_min;
                                out_index_next = IW'(ins_pos);
                                out_total_next = TW'(count_reg + 1'b1);
                                out_drop_next  = 1'b0;
                            end
                        end
                        sit_pkg::CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                out_index_next = '0;
                                out_total_next = '0;
                                out_drop_next  = 1'b0;
                                out_last_next  = 1'b1;
                            end
                            else
                            begin
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        sit_pkg::CMD_CLEAR:
                        begin
                            count_next     = '0;
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_index_next = '0;
                            out_total_next = '0;
                            out_drop_next  = 1'b0;
                            out_last_next  = 1'b1;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (can_load)
                begin
                    // slot 0 always holds the entry at dump_idx while rotating
                    ctl.op         = sit_pkg::CELL_ROTATE;
                    out_valid_next = 1'b1;
                    out_value_next = cell_val[0];
                    out_index_next = IW'(dump_idx_reg);
                    out_total_next = TW'(count_reg);
                    out_drop_next  = 1'b0;
                    out_last_next  = (dump_idx_reg + 1'b1) == count_reg;
                    dump_idx_next  = dump_idx_reg + 1'b1;
                    if ((dump_idx_reg + 1'b1) == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_total_reg <= out_total_next;
        out_drop_reg  <= out_drop_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.result_index = out_index_reg;
    assign out_ch.entry_total  = out_total_reg;
    assign out_ch.dropped      = out_drop_reg;
    assign out_ch.last_of_run  = out_last_reg;

endmodule

@@ hdl/sit_cell.sv @@
// ============================================================================
// sit_cell: one slot of the sorted chain
// Compares its entry against the incoming value, shifts up from its left
// neighbor on insert and takes its right neighbor's entry on rotate.
// ============================================================================
module sit_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                                clk,
    input  sit_pkg::cell_ctl_t                  ctl,
    input  logic [CW-1:0]                       count,
    input  logic signed [sit_pkg::VALUE_W-1:0]  left_value,
    input  logic                                left_gt,
    input  logic signed [sit_pkg::VALUE_W-1:0]  right_value,
    input  logic signed [sit_pkg::VALUE_W-1:0]  first_value,
    output logic signed [sit_pkg::VALUE_W-1:0]  value,
    output logic                                gt,
    output logic                                take_new
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);

    logic signed [sit_pkg::VALUE_W-1:0] val_reg;
    logic signed [sit_pkg::VALUE_W-1:0] val_next;
    logic                               occupied;
    logic                               at_end;
    logic                               moves;

    assign occupied = IDX_C < count;
    assign at_end   = IDX_C == count;
    assign gt       = occupied && (val_reg > ctl.new_value);
    // slot changes on insert if it sits at or past the insert point
    assign moves    = gt || at_end;
    assign take_new = (ctl.op == sit_pkg::CELL_INSERT) && moves && !left_gt;

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            sit_pkg::CELL_INSERT:
            begin
                if (moves)
                begin
                    val_next = left_gt ? left_value : ctl.new_value;
                end
            end
            sit_pkg::CELL_ROTATE:
            begin
                // rotate the occupied run left by one; head wraps to the tail
                if (NEXT_C < count)
                begin
                    val_next = right_value;
                end
                else if (NEXT_C == count)
                begin
                    val_next = first_value;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

@@ hdl/sit_checker.sv @@
// ============================================================================
// sit_checker: port-level checks for the sorted insert table
// Watches the command and result channels and flags sequencing errors.
// ============================================================================
module sit_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [sit_pkg::VALUE_W-1:0]  result_value,
    input  logic [sit_pkg::INDEX_W-1:0]         result_index,
    input  logic [sit_pkg::TOTAL_W-1:0]         entry_total,
    input  logic                                dropped,
    input  logic                                last_of_run
);

    localparam logic [sit_pkg::TOTAL_W-1:0] DEPTH_T = sit_pkg::TOTAL_W'(TABLE_DEPTH);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result word changed while stalled");

    // a refused insert only happens on a full table and ends its run
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> last_of_run && entry_total == DEPTH_T)
        else $error("dropped word without full table");

    // no command is taken while a dump is mid-stream
    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("command accepted during dump");

    // dump words follow back to back with rising index
    a_dump_next: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=>
            out_valid && result_index == $past(result_index) + 1'b1)
        else $error("dump stream broken");

endmodule

bind sorted_insert_table sit_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sit_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_value (out_ch.result_value),
    .result_index (out_ch.result_index),
    .entry_total  (out_ch.entry_total),
    .dropped      (out_ch.dropped),
    .last_of_run  (out_ch.last_of_run)
);

@@ bench/sorted_insert_table_tb.sv @@
// ============================================================================
// sorted_insert_table_tb: self-checking bench for the sorted insert table
// Drives insert, dump, clear and unused command words with random gaps and
// receiver stalls. A local copy of the table predicts every result word,
// and each received word is checked field by field against the oldest
// prediction.
// ============================================================================
module sorted_insert_table_tb;

    localparam int DEPTH        = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;

    // code 3 has no meaning; the block takes it and does nothing
    localparam logic [sit_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [sit_pkg::VALUE_W-1:0] value;
        logic [sit_pkg::INDEX_W-1:0]        index;
        logic [sit_pkg::TOTAL_W-1:0]        total;
        logic                               dropped;
        logic                               last;
    } rsp_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sit_cmd_if cmd_ch ();
    sit_rsp_if rsp_ch ();

    sorted_insert_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (rsp_ch)
    );

    // local copy of the table and the words it predicts
    logic signed [sit_pkg::VALUE_W-1:0] sorted_copy [DEPTH];
    int unsigned                        copy_count = 0;
    rsp_word_t                          expected_words [$];

    int error_count = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [sit_pkg::VALUE_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            1, 2, 3: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic rsp_word_t make_word(
        input logic signed [sit_pkg::VALUE_W-1:0] value,
        input int unsigned index,
        input int unsigned total,
        input logic dropped,
        input logic last);
        rsp_word_t w;
        w.value   = value;
        w.index   = index[sit_pkg::INDEX_W-1:0];
        w.total   = total[sit_pkg::TOTAL_W-1:0];
        w.dropped = dropped;
        w.last    = last;
        return w;
    endfunction

    task automatic predict_table_words(input logic [sit_pkg::CMD_W-1:0] cmd,
                                       input logic signed [sit_pkg::VALUE_W-1:0] val);
        int unsigned slot;
        int unsigned j;
        case (cmd)
            sit_pkg::CMD_INSERT:
            begin
                if (copy_count >= DEPTH)
                begin
                    expected_words.push_back(
                        make_word(sorted_copy[0], 0, copy_count, 1'b1, 1'b1));
                end
                else
                begin
                    // first entry strictly greater; equal values stay in arrival order
                    slot = 0;
                    while (slot < copy_count && sorted_copy[slot] <= val)
                        slot++;
                    for (j = copy_count; j > slot; j--)
                        sorted_copy[j] = sorted_copy[j-1];
                    sorted_copy[slot] = val;
                    copy_count++;
                    expected_words.push_back(
                        make_word(sorted_copy[0], slot, copy_count, 1'b0, 1'b1));
                end
            end
            sit_pkg::CMD_DUMP:
            begin
                if (copy_count == 0)
                    expected_words.push_back(make_word('0, 0, 0, 1'b0, 1'b1));
                else
                    for (j = 0; j < copy_count; j++)
                        expected_words.push_back(make_word(sorted_copy[j], j, copy_count,
                                                           1'b0, j + 1 == copy_count));
            end
            sit_pkg::CMD_CLEAR:
            begin
                copy_count = 0;
                expected_words.push_back(make_word('0, 0, 0, 1'b0, 1'b1));
            end
            default:
            begin
            end
        endcase
    endtask

    // predict on accepted commands, check accepted results, watch for a hang
    always @(posedge clk)
    begin : monitor
        rsp_word_t want;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_table_words(cmd_ch.command, cmd_ch.new_value);
                moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: value %0d index %0d total %0d",
                           rsp_ch.result_value, rsp_ch.result_index, rsp_ch.entry_total);
                    error_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp_ch.result_value !== want.value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               want.value, rsp_ch.result_value);
                        error_count++;
                    end
                    if (rsp_ch.result_index !== want.index)
                    begin
                        $error("result_index: expected %0d, got %0d",
                               want.index, rsp_ch.result_index);
                        error_count++;
                    end
                    if (rsp_ch.entry_total !== want.total)
                    begin
                        $error("entry_total: expected %0d, got %0d",
                               want.total, rsp_ch.entry_total);
                        error_count++;
                    end
                    if (rsp_ch.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %0b, got %0b",
                               want.dropped, rsp_ch.dropped);
                        error_count++;
                    end
                    if (rsp_ch.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last, rsp_ch.last_of_run);
                        error_count++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("sorted_insert_table_tb NOT OK");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                stall = pick_gap(take_steady);
            end
        end
    end

    // one command word; valid stays up into the next word unless a gap is drawn
    task automatic send_word(input logic [sit_pkg::CMD_W-1:0] cmd,
                             input logic signed [sit_pkg::VALUE_W-1:0] val);
        int unsigned gap;
        gap = pick_gap(send_steady);
        if (gap > 0)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.command   <= sit_pkg::CMD_W'($urandom);
            cmd_ch.new_value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.new_value <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic test_directed();
        send_word(sit_pkg::CMD_DUMP, pick_value());      // empty table
        send_word(sit_pkg::CMD_INSERT, 32'sh7fff_ffff);
        send_word(sit_pkg::CMD_INSERT, 32'sh8000_0000);
        send_word(sit_pkg::CMD_INSERT, 32'sd0);
        send_word(sit_pkg::CMD_INSERT, 32'sd0);          // equal value lands after the first
        send_word(sit_pkg::CMD_INSERT, -32'sd1);
        send_word(sit_pkg::CMD_INSERT, 32'sd5);
        send_word(sit_pkg::CMD_DUMP, pick_value());
        send_word(CMD_UNUSED, pick_value());
        send_word(sit_pkg::CMD_CLEAR, pick_value());
        send_word(sit_pkg::CMD_DUMP, pick_value());
        send_word(sit_pkg::CMD_INSERT, 32'sd7);
        send_word(sit_pkg::CMD_DUMP, pick_value());
    endtask

    task automatic test_full_table();
        send_word(sit_pkg::CMD_CLEAR, pick_value());
        repeat (DEPTH)
            send_word(sit_pkg::CMD_INSERT, pick_value());
        send_word(sit_pkg::CMD_INSERT, 32'sh8000_0000);  // full: refused
        send_word(sit_pkg::CMD_INSERT, pick_value());
        send_word(sit_pkg::CMD_DUMP, pick_value());
    endtask

    task automatic test_random_mix(input int unsigned words);
        int unsigned sent;
        int unsigned r;
        sent = 0;
        while (sent < words)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
                send_word(sit_pkg::CMD_INSERT, pick_value());
            else if (r < 85)
                send_word(sit_pkg::CMD_DUMP, pick_value());
            else if (r < 93)
                send_word(sit_pkg::CMD_CLEAR, pick_value());
            else
                send_word(CMD_UNUSED, pick_value());
            if (r < 93)
                sent++;
        end
    endtask

    task automatic test_steady_stream();
        send_steady = 1'b1;
        take_steady = 1'b1;
        test_random_mix(50);
        send_steady = 1'b0;
        take_steady = 1'b0;
    endtask

    // receiver held off while the sender keeps offering words
    task automatic test_backpressure();
        hold_left   = HOLD_CYCLES;
        send_steady = 1'b1;
        send_word(sit_pkg::CMD_CLEAR, pick_value());
        repeat (18)
            send_word(sit_pkg::CMD_INSERT, pick_value());
        send_word(sit_pkg::CMD_DUMP, pick_value());
        send_word(sit_pkg::CMD_INSERT, pick_value());
        send_steady = 1'b0;
    endtask

    initial
    begin
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = sit_pkg::CMD_INSERT;
        cmd_ch.new_value = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random_mix(300);
        test_steady_stream();
        test_backpressure();

        cmd_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sorted_insert_table_tb OK");
        else
            $display("sorted_insert_table_tb NOT OK");
        $finish;
    end

endmodule
